### rtl/qti_pkg.sv
package qti_pkg;

  localparam int QTI_MAX_POINTS = 64;
  localparam int QTI_MIN_POINTS = 3;
  localparam int QTI_COUNT_W    = 7;
  localparam logic [QTI_COUNT_W-1:0] QTI_COUNT_RESET = 7'd3;

  // Operand and result widths of the shared multiply and divide units.
  localparam int QTI_MUL_A_W  = 64;
  localparam int QTI_MUL_B_W  = 33;
  localparam int QTI_PROD_W   = 96;
  localparam int QTI_DEN_W    = 64;
  localparam int QTI_MAG_W    = 62;
  localparam int QTI_MUL_STEPS = QTI_MUL_B_W;
  localparam int QTI_DIV_STEPS = QTI_PROD_W;

  localparam logic [QTI_MAG_W-1:0] QTI_TERM_LIMIT = 62'h2000_0000_0000_0000;

  localparam logic QTI_REQ_WRITE = 1'b0;
  localparam logic QTI_REQ_QUERY = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [5:0]        point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } qti_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic signed [31:0] curvature;
    logic              status;
  } qti_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_PT_RD,
    ST_PT_CAP,
    ST_CHECK,
    ST_M_DEN,
    ST_M_YF,
    ST_M_YFF,
    ST_D_V,
    ST_M_S,
    ST_D_S,
    ST_D_C,
    ST_FINAL,
    ST_DONE
  } qti_state_e;

  // Magnitude of a 33-bit signed difference; always fits in 32 bits.
  function automatic logic [31:0] qti_mag33(input logic signed [32:0] v);
    logic [32:0] n;
    n = v[32] ? 33'(-v) : 33'(v);
    return n[31:0];
  endfunction

  // Saturate a 64-bit sum to the signed 32-bit range.
  function automatic logic signed [31:0] qti_sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/qti_mul.sv
module qti_mul import qti_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [QTI_MUL_A_W-1:0] a_i,
  input  logic [QTI_MUL_B_W-1:0] b_i,
  output logic [QTI_PROD_W-1:0]  prod_o,
  output logic                   done_o
);

  localparam int CntW = $clog2(QTI_MUL_STEPS + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [QTI_PROD_W-1:0] acc_q;
  logic [QTI_PROD_W-1:0] a_sh_q;
  logic [QTI_MUL_B_W-1:0] b_sh_q;

  // Shift-and-add: one multiplier bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QTI_MUL_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      a_sh_q <= QTI_PROD_W'(a_i);
      b_sh_q <= b_i;
    end else if (busy_q) begin
      if (b_sh_q[0]) begin
        acc_q <= acc_q + a_sh_q;
      end
      a_sh_q <= a_sh_q << 1;
      b_sh_q <= b_sh_q >> 1;
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

### rtl/qti_div.sv
module qti_div import qti_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [QTI_PROD_W-1:0] num_i,
  input  logic [QTI_DEN_W-1:0]  den_i,
  output logic [QTI_MAG_W-1:0]  mag_o,
  output logic                  done_o
);

  localparam int CntW = $clog2(QTI_DIV_STEPS + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [QTI_PROD_W-1:0] num_q;
  logic [QTI_PROD_W-1:0] quo_q;
  logic [QTI_DEN_W-1:0]  rem_q;
  logic [QTI_DEN_W-1:0]  den_q;
  logic [QTI_DEN_W:0]    rem_sh;
  logic                  ge;
  logic [QTI_DEN_W:0]    rem_dbl;
  logic                  rnd;
  logic [QTI_MAG_W:0]    rounded;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q, num_q[QTI_PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QTI_DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[QTI_PROD_W-2:0], ge};
      rem_q <= ge ? QTI_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[QTI_DEN_W-1:0];
    end
  end

  // Round half away from zero on the magnitude, then clamp to the term limit.
  assign rem_dbl = {rem_q, 1'b0};
  assign rnd     = rem_dbl >= {1'b0, den_q};
  assign rounded = {1'b0, quo_q[QTI_MAG_W-1:0]} + (QTI_MAG_W+1)'(rnd);

  always_comb begin
    if (quo_q[QTI_PROD_W-1:QTI_MAG_W] != '0) begin
      mag_o = QTI_TERM_LIMIT;
    end else if (rounded > {1'b0, QTI_TERM_LIMIT}) begin
      mag_o = QTI_TERM_LIMIT;
    end else begin
      mag_o = rounded[QTI_MAG_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

### rtl/quadratic_table_interpolator.sv
// Three-point quadratic table interpolator. Point writes (req_type 0) store one
// (x, y) sample in the table and return no transaction on the output. A query
// (req_type 1) binary-searches the first point_count table entries (clamped to
// 3..MAX_POINTS) for the interval that holds query_x, picks three neighboring
// points, fits the Lagrange quadratic through them and returns value, slope and
// curvature in signed Q16.16, saturated, or zeros with status 1 when the chosen
// abscissas are not properly spaced. After the search and the point fetch, a
// query runs, per chosen point, four multiplies and three divides on the one
// shared shift-and-add multiplier and the one shared restoring divider, which
// retire one bit per cycle. The block takes one transaction at a time; it holds
// a finished result in an output register until the consumer takes it.
module quadratic_table_interpolator import qti_pkg::*; #(
  parameter int MAX_POINTS = QTI_MAX_POINTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  qti_in_t                in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output qti_out_t               out_item_o,
  input  logic                   cfg_we_i,
  input  logic [QTI_COUNT_W-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(MAX_POINTS);

  // Table memories, one write and one registered read port each.
  logic signed [31:0] abs_mem [MAX_POINTS];
  logic signed [31:0] ord_mem [MAX_POINTS];
  logic signed [31:0] rd_x_q;
  logic signed [31:0] rd_y_q;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [31:0]        slot_ext;
  logic [AW-1:0]      wr_addr;
  logic               slot_ok;

  logic [QTI_COUNT_W-1:0] count_q;

  qti_state_e state_q, state_d;
  logic signed [31:0] x_q, x_d;
  logic [AW-1:0]      nm1_q, nm1_d;
  logic [AW-1:0]      lo_q, lo_d;
  logic [AW-1:0]      hi_q, hi_d;
  logic [AW-1:0]      mid_q, mid_d;
  logic [AW-1:0]      base_q, base_d;
  logic [1:0]         k_q, k_d;
  logic [1:0]         pi_q, pi_d;
  logic               issued_q, issued_d;
  logic signed [31:0] xs_q [3];
  logic signed [31:0] xs_d [3];
  logic signed [31:0] ys_q [3];
  logic signed [31:0] ys_d [3];
  logic [QTI_DEN_W-1:0] den_q, den_d;
  logic signed [63:0] acc_v_q, acc_v_d;
  logic signed [63:0] acc_s_q, acc_s_d;
  logic signed [63:0] acc_c_q, acc_c_d;
  qti_out_t           res_q, res_d;
  qti_out_t           out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [31:0]        cnt_ext;
  logic [31:0]        n_ext;
  logic [AW:0]        mid_sum;

  // Arithmetic unit hookup.
  logic                   mul_start;
  logic [QTI_MUL_A_W-1:0] mul_a;
  logic [QTI_MUL_B_W-1:0] mul_b;
  logic [QTI_PROD_W-1:0]  mul_prod;
  logic                   mul_done;
  logic                   div_start;
  logic [QTI_PROD_W-1:0]  div_num;
  logic [QTI_MAG_W-1:0]   div_mag;
  logic                   div_done;

  // Terms of the current Lagrange basis point.
  logic [1:0]         j_idx, kk_idx;
  logic signed [31:0] xi, xj, xk, yi;
  logic signed [32:0] dj, dk, fj, fk;
  logic signed [33:0] fs;
  logic [31:0]        dj_m, dk_m, fj_m, fk_m, y_m;
  logic [32:0]        fs_m;
  logic               neg_v, neg_s, neg_c;
  logic signed [63:0] term_pos, term_neg;
  logic signed [32:0] gap_hi;
  logic               bad_spacing;

  qti_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  qti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .mag_o   (div_mag),
    .done_o  (div_done)
  );

  // A write to a slot beyond the table is dropped.
  assign slot_ext = 32'(in_item_i.point_index);
  assign wr_addr  = slot_ext[AW-1:0];
  assign slot_ok  = slot_ext < 32'(MAX_POINTS);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      abs_mem[wr_addr] <= in_item_i.point_x;
      ord_mem[wr_addr] <= in_item_i.point_y;
    end
    rd_x_q <= abs_mem[rd_addr];
    rd_y_q <= ord_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= QTI_COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Point count clamped to the legal range.
  assign cnt_ext = 32'(count_q);
  always_comb begin
    if (cnt_ext < 32'(QTI_MIN_POINTS)) begin
      n_ext = 32'(QTI_MIN_POINTS);
    end else if (cnt_ext > 32'(MAX_POINTS)) begin
      n_ext = 32'(MAX_POINTS);
    end else begin
      n_ext = cnt_ext;
    end
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

  // The point being weighted is pi; the other two follow it cyclically.
  always_comb begin
    case (pi_q)
      2'd0: begin
        j_idx  = 2'd1;
        kk_idx = 2'd2;
      end
      2'd1: begin
        j_idx  = 2'd2;
        kk_idx = 2'd0;
      end
      default: begin
        j_idx  = 2'd0;
        kk_idx = 2'd1;
      end
    endcase
  end

  assign xi = xs_q[pi_q];
  assign xj = xs_q[j_idx];
  assign xk = xs_q[kk_idx];
  assign yi = ys_q[pi_q];
  assign dj = {xi[31], xi} - {xj[31], xj};
  assign dk = {xi[31], xi} - {xk[31], xk};
  assign fj = {x_q[31], x_q} - {xj[31], xj};
  assign fk = {x_q[31], x_q} - {xk[31], xk};
  assign fs = {fj[32], fj} + {fk[32], fk};

  assign dj_m = qti_mag33(dj);
  assign dk_m = qti_mag33(dk);
  assign fj_m = qti_mag33(fj);
  assign fk_m = qti_mag33(fk);
  assign y_m  = qti_mag33({yi[31], yi});
  assign fs_m = fs[33] ? 33'(-fs) : fs[32:0];

  assign neg_c = yi[31] ^ dj[32] ^ dk[32];
  assign neg_v = neg_c ^ fj[32] ^ fk[32];
  assign neg_s = neg_c ^ fs[33];

  assign term_pos = 64'(div_mag);
  assign term_neg = -term_pos;

  assign gap_hi      = {xs_q[2][31], xs_q[2]} - {xs_q[1][31], xs_q[1]};
  assign bad_spacing = (gap_hi[32] || gap_hi == '0) || (xs_q[0] == xs_q[1]) ||
                       (xs_q[0] == xs_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    nm1_q   <= nm1_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    base_q  <= base_d;
    k_q     <= k_d;
    pi_q    <= pi_d;
    xs_q    <= xs_d;
    ys_q    <= ys_d;
    den_q   <= den_d;
    acc_v_q <= acc_v_d;
    acc_s_q <= acc_s_d;
    acc_c_q <= acc_c_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    nm1_d       = nm1_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    base_d      = base_q;
    k_d         = k_q;
    pi_d        = pi_q;
    issued_d    = issued_q;
    xs_d        = xs_q;
    ys_d        = ys_q;
    den_d       = den_q;
    acc_v_d     = acc_v_q;
    acc_s_d     = acc_s_q;
    acc_c_d     = acc_c_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    rd_addr     = '0;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_num     = '0;
    in_stall_o  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_item_i.req_type == QTI_REQ_WRITE) begin
            mem_we = slot_ok;
          end else begin
            x_d     = in_item_i.query_x;
            nm1_d   = AW'(n_ext - 32'd1);
            lo_d    = '0;
            hi_d    = AW'(n_ext - 32'd1);
            state_d = ST_SRCH;
          end
        end
      end

      ST_SRCH: begin
        if ({1'b0, hi_q} > ({1'b0, lo_q} + 1'b1)) begin
          mid_d   = mid_sum[AW:1];
          rd_addr = mid_sum[AW:1];
          state_d = ST_SRCH_CMP;
        end else begin
          // Low end takes the first three points, high end the last three.
          if (lo_q == '0) begin
            base_d = '0;
          end else if (lo_q >= nm1_q) begin
            base_d = nm1_q - AW'(2);
          end else begin
            base_d = lo_q - 1'b1;
          end
          k_d     = 2'd0;
          state_d = ST_PT_RD;
        end
      end

      ST_SRCH_CMP: begin
        if (rd_x_q > x_q) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q;
        end
        state_d = ST_SRCH;
      end

      ST_PT_RD: begin
        rd_addr = base_q + AW'(k_q);
        state_d = ST_PT_CAP;
      end

      ST_PT_CAP: begin
        xs_d[k_q] = rd_x_q;
        ys_d[k_q] = rd_y_q;
        if (k_q == 2'd2) begin
          state_d = ST_CHECK;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_PT_RD;
        end
      end

      ST_CHECK: begin
        if (bad_spacing) begin
          res_d.value     = '0;
          res_d.slope     = '0;
          res_d.curvature = '0;
          res_d.status    = 1'b1;
          state_d         = ST_DONE;
        end else begin
          acc_v_d  = '0;
          acc_s_d  = '0;
          acc_c_d  = '0;
          pi_d     = 2'd0;
          issued_d = 1'b0;
          state_d  = ST_M_DEN;
        end
      end

      // Denominator of the basis polynomial: (xi - xj)(xi - xk).
      ST_M_DEN: begin
        mul_a     = QTI_MUL_A_W'(dj_m);
        mul_b     = QTI_MUL_B_W'(dk_m);
        mul_start = !issued_q;
        issued_d  = 1'b1;
        if (mul_done) begin
          den_d    = mul_prod[QTI_DEN_W-1:0];
          issued_d = 1'b0;
          state_d  = ST_M_YF;
        end
      end

      ST_M_YF: begin
        mul_a     = QTI_MUL_A_W'(y_m);
        mul_b     = QTI_MUL_B_W'(fj_m);
        mul_start = !issued_q;
        issued_d  = 1'b1;
        if (mul_done) begin
          issued_d = 1'b0;
          state_d  = ST_M_YFF;
        end
      end

      ST_M_YFF: begin
        mul_a     = mul_prod[QTI_MUL_A_W-1:0];
        mul_b     = QTI_MUL_B_W'(fk_m);
        mul_start = !issued_q;
        issued_d  = 1'b1;
        if (mul_done) begin
          issued_d = 1'b0;
          state_d  = ST_D_V;
        end
      end

      ST_D_V: begin
        div_num   = mul_prod;
        div_start = !issued_q;
        issued_d  = 1'b1;
        if (div_done) begin
          acc_v_d  = acc_v_q + (neg_v ? term_neg : term_pos);
          issued_d = 1'b0;
          state_d  = ST_M_S;
        end
      end

      ST_M_S: begin
        mul_a     = {16'b0, y_m, 16'b0};
        mul_b     = fs_m;
        mul_start = !issued_q;
        issued_d  = 1'b1;
        if (mul_done) begin
          issued_d = 1'b0;
          state_d  = ST_D_S;
        end
      end

      ST_D_S: begin
        div_num   = mul_prod;
        div_start = !issued_q;
        issued_d  = 1'b1;
        if (div_done) begin
          acc_s_d  = acc_s_q + (neg_s ? term_neg : term_pos);
          issued_d = 1'b0;
          state_d  = ST_D_C;
        end
      end

      // Curvature numerator is y * 2^33, a plain shift.
      ST_D_C: begin
        div_num   = {31'b0, y_m, 33'b0};
        div_start = !issued_q;
        issued_d  = 1'b1;
        if (div_done) begin
          acc_c_d  = acc_c_q + (neg_c ? term_neg : term_pos);
          issued_d = 1'b0;
          if (pi_q == 2'd2) begin
            state_d = ST_FINAL;
          end else begin
            pi_d    = pi_q + 1'b1;
            state_d = ST_M_DEN;
          end
        end
      end

      ST_FINAL: begin
        res_d.value     = qti_sat32(acc_v_q);
        res_d.slope     = qti_sat32(acc_s_q);
        res_d.curvature = qti_sat32(acc_c_q);
        res_d.status    = 1'b0;
        state_d         = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // An invalid-spacing result carries only zeros.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status |->
      out_item_o.value == '0 && out_item_o.slope == '0 && out_item_o.curvature == '0)
    else $error("invalid-spacing result with nonzero values");

  // The probe lies strictly inside the search window.
  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH_CMP |-> lo_q < mid_q && mid_q < hi_q)
    else $error("search probe outside window");

  // The three chosen points stay within the points in use.
  a_fetch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PT_RD |-> ({1'b0, base_q} + (AW+1)'(k_q)) <= {1'b0, nm1_q})
    else $error("point fetch beyond table end");

  // A new result appears only when a query completes.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("output valid raised outside completion");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

// Testbench for the quadratic table interpolator.
//
// The table is loaded with point writes. Queries are then issued against it under
// a series of point_count settings. The settings include the clamped values below
// 3 and above the table depth. The table shapes vary: sorted with wide spacing,
// sorted with tight spacing, sorted with repeated abscissas, and unsorted.
//
// Every query is predicted in the scoreboard by an exact 128-bit Lagrange
// evaluation. The prediction is compared field by field with the output
// transaction. Both the input and the output side idle at random, except for one
// phase that runs at full rate.

class interp_scoreboard;
  longint abscissa[64];
  longint ordinate[64];
  int     active_count;
  qti_pkg::qti_out_t expected_q[$];
  int     error_count;
  int     query_count;
  int     invalid_count;
  int     saturated_count;

  function new();
    active_count = 3;
    error_count = 0;
    query_count = 0;
    invalid_count = 0;
    saturated_count = 0;
    foreach (abscissa[i]) begin
      abscissa[i] = 0;
      ordinate[i] = 0;
    end
  endfunction

  function logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // y * 2^sh * f1 * f2 / (d1 * d2), rounded half away from zero and clamped to 2^61.
  function longint lagrange_term(longint y, int sh, longint f1, longint f2,
                                 longint d1, longint d2);
    logic         neg;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    logic [127:0] rem;
    longint       mag_res;
    neg = (y < 0) ^ (f1 < 0) ^ (f2 < 0) ^ (d1 < 0) ^ (d2 < 0);
    num = (128'(magnitude(y)) << sh) * 128'(magnitude(f1)) * 128'(magnitude(f2));
    den = 128'(magnitude(d1)) * 128'(magnitude(d2));
    quo = num / den;
    rem = num % den;
    if ((rem << 1) >= den) begin
      quo = quo + 1;
    end
    if (quo > (128'd1 << 61)) begin
      quo = 128'd1 << 61;
    end
    mag_res = longint'(quo[63:0]);
    return neg ? -mag_res : mag_res;
  endfunction

  function logic signed [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function void set_count(logic [6:0] v);
    active_count = v;
  endfunction

  // Called for every accepted input transaction.
  function void note_input(qti_pkg::qti_in_t item);
    int     n;
    int     lo;
    int     hi;
    int     mid;
    int     base;
    longint x;
    longint xs[3];
    longint ys[3];
    longint val;
    longint slp;
    longint crv;
    qti_pkg::qti_out_t res;
    if (item.req_type == qti_pkg::QTI_REQ_WRITE) begin
      abscissa[item.point_index] = longint'(item.point_x);
      ordinate[item.point_index] = longint'(item.point_y);
      return;
    end
    n = active_count;
    if (n < 3) n = 3;
    if (n > 64) n = 64;
    x = longint'(item.query_x);
    lo = 0;
    hi = n - 1;
    while (hi > lo + 1) begin
      mid = (lo + hi) / 2;
      if (abscissa[mid] > x) begin
        hi = mid;
      end else begin
        lo = mid;
      end
    end
    base = (lo < 1) ? 0 : ((lo > n - 2) ? n - 3 : lo - 1);
    for (int i = 0; i < 3; i++) begin
      xs[i] = abscissa[base + i];
      ys[i] = ordinate[base + i];
    end
    query_count++;
    res = '0;
    if (xs[2] - xs[1] <= 0 || xs[0] == xs[1] || xs[0] == xs[2]) begin
      res.status = 1'b1;
      invalid_count++;
    end else begin
      val = 0;
      slp = 0;
      crv = 0;
      for (int i = 0; i < 3; i++) begin
        int j;
        int k;
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        val += lagrange_term(ys[i], 0, x - xs[j], x - xs[k], xs[i] - xs[j], xs[i] - xs[k]);
        slp += lagrange_term(ys[i], 16, (x - xs[j]) + (x - xs[k]), 1,
                             xs[i] - xs[j], xs[i] - xs[k]);
        crv += lagrange_term(ys[i], 32, 2, 1, xs[i] - xs[j], xs[i] - xs[k]);
      end
      res.value = clamp32(val);
      res.slope = clamp32(slp);
      res.curvature = clamp32(crv);
      if (val != longint'(res.value)) saturated_count++;
    end
    expected_q.push_back(res);
  endfunction

  // Called for every accepted output transaction.
  function void check_result(qti_pkg::qti_out_t got);
    qti_pkg::qti_out_t want;
    if (expected_q.size() == 0) begin
      $error("output transaction with no query outstanding");
      error_count++;
      return;
    end
    want = expected_q.pop_front();
    if (got.value !== want.value) begin
      $error("value: expected %0d, actual %0d", want.value, got.value);
      error_count++;
    end
    if (got.slope !== want.slope) begin
      $error("slope: expected %0d, actual %0d", want.slope, got.slope);
      error_count++;
    end
    if (got.curvature !== want.curvature) begin
      $error("curvature: expected %0d, actual %0d", want.curvature, got.curvature);
      error_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0b, actual %0b", want.status, got.status);
      error_count++;
    end
  endfunction
endclass

module testbench;
  import qti_pkg::*;

  // Shapes of table that a phase loads.
  localparam int ShapeWide   = 0;
  localparam int ShapeTight  = 1;
  localparam int ShapeRepeat = 2;
  localparam int ShapeRandom = 3;

  // This limit is far above the time that any query takes to finish, so it is far above any
  // correct stretch with no transaction.
  localparam int StallLimit = 40000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  qti_in_t    in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  qti_out_t   out_item;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = QTI_COUNT_RESET;

  // full_rate shapes the random idling: it turns idling off on both sides. quiet_cycles feeds the watchdog.
  bit full_rate = 1'b0;
  int quiet_cycles = 0;

  // The stimulus side keeps its own copy of the table abscissas so that it can aim
  // queries near the points.
  logic signed [31:0] loaded_x[64];

  interp_scoreboard board = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quadratic_table_interpolator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // The monitor samples at the edge, before any of that edge's updates land. It
  // also keeps the watchdog on transactions.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) begin
        board.set_count(cfg_wdata);
      end
      if (in_valid && !in_stall) begin
        board.note_input(in_item);
      end
      if (out_valid && !out_stall) begin
        board.check_result(out_item);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The consumer stalls at random, with a chance of 12 in a hundred, unless full_rate is set.
  always @(posedge clk_i) begin
    out_stall <= !full_rate && ($urandom_range(0, 99) < 12);
  end

  // Presents one transaction and holds it until it is taken. The caller's next
  // call may raise valid again in the same step, which is a single assignment.
  task automatic send_item(qti_in_t item);
    if (!full_rate && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic write_point(int slot, logic signed [31:0] px, logic signed [31:0] py);
    qti_in_t item;
    item = '0;
    item.req_type = QTI_REQ_WRITE;
    item.point_index = slot[5:0];
    item.point_x = px;
    item.point_y = py;
    item.query_x = $urandom;
    loaded_x[slot] = px;
    send_item(item);
  endtask

  task automatic query_at(logic signed [31:0] qx);
    qti_in_t item;
    item = '0;
    item.req_type = QTI_REQ_QUERY;
    item.point_index = $urandom;
    item.point_x = $urandom;
    item.point_y = $urandom;
    item.query_x = qx;
    send_item(item);
  endtask

  // The sender holds back until every query has returned and the block has settled.
  // Only then may the count register change.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] count);
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Loads all 64 slots in a random order of slots, so the index bits all toggle.
  task automatic load_table(int shape);
    longint px;
    longint step_max;
    int     order[64];
    longint xs[64];
    logic signed [31:0] py;
    if (shape == ShapeWide) begin
      step_max = (64'd1 << 26) - 1;
      px = -(64'd1 << 31) + $urandom_range(0, 1 << 20);
    end else begin
      step_max = (shape == ShapeTight) ? 256 : 64;
      px = longint'($signed($urandom_range(0, 1 << 21))) - (1 << 20);
    end
    for (int i = 0; i < 64; i++) begin
      order[i] = i;
      if (shape == ShapeRandom) begin
        xs[i] = longint'($signed(32'($urandom)));
      end else begin
        xs[i] = px;
        if (shape == ShapeRepeat && $urandom_range(0, 7) == 0) begin
          px = px;
        end else begin
          px = px + 1 + longint'($urandom_range(0, 32'(step_max - 1)));
        end
      end
    end
    order.shuffle();
    for (int i = 0; i < 64; i++) begin
      py = ($urandom_range(0, 3) == 0) ? 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19))
                                        : 32'($urandom);
      write_point(order[i], xs[order[i]][31:0], py);
    end
  endtask

  function automatic logic signed [31:0] pick_query();
    int slot;
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000 + $urandom_range(0, 3);
      1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
      2, 3: begin
        slot = $urandom_range(0, 63);
        return loaded_x[slot] + 32'($signed($urandom_range(0, 512)) - 256);
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [6:0] phase_counts[12];
    int         phase_queries;

    phase_counts = '{7'd64, 7'd4, 7'd127, 7'd0, 7'd33, 7'd2, 7'd65, 7'd17, 7'd64,
                     7'd10, 7'd3, 7'd1};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed part runs at the reset count of three points. It covers the
    // extreme abscissas and ordinates, queries at both range ends, and bad spacing
    // with x0 equal to x1 and with x2 equal to x1.
    write_point(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    write_point(1, 32'sh0000_0000, 32'sh8000_0000);
    write_point(2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    query_at(32'sh8000_0000);
    query_at(32'sh7FFF_FFFF);
    query_at(32'sh0000_0000);
    query_at(32'sh0001_0000);
    write_point(0, 32'sh0000_0000, 32'sh0001_0000);
    query_at(32'sh0000_8000);
    write_point(0, 32'shFFFF_0000, 32'sh0001_0000);
    write_point(2, 32'sh0000_0000, 32'sh0002_0000);
    query_at(32'sh0000_0000);
    write_point(1, 32'sh0000_0001, 32'sh0000_0000);
    write_point(2, 32'sh0000_0002, 32'sh7FFF_FFFF);
    query_at(32'sh7FFF_FFFF);
    query_at(32'sh8000_0000);
    drain();

    // Each phase below sets a new count, loads a full table and then runs queries
    // mixed with stray point writes. The drain at the end of a phase lets every
    // result come back before the next phase begins.
    for (int p = 0; p < 12; p++) begin
      full_rate = (p == 4);
      write_count(phase_counts[p]);
      load_table(p % 4);
      phase_queries = 90 + $urandom_range(0, 20);
      for (int q = 0; q < phase_queries; q++) begin
        if ($urandom_range(0, 99) < 5) begin
          write_point($urandom_range(0, 63), $urandom, $urandom);
        end else begin
          query_at(pick_query());
        end
      end
      drain();
    end
    full_rate = 1'b0;

    repeat (50) @(posedge clk_i);
    $display("Covered %0d queries (%0d with bad spacing, %0d with a saturated value)",
             board.query_count, board.invalid_count, board.saturated_count);
    $display("over 13 count settings and four table shapes.");
    if (board.error_count == 0 && board.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### quadratic_table_interpolator.f
rtl/qti_pkg.sv
rtl/qti_mul.sv
rtl/qti_div.sv
rtl/quadratic_table_interpolator.sv
verif/testbench.sv
